FILE: hdl/swm_pkg.sv
// shared types and constants of the sliding window median filter
`default_nettype none
package swm_pkg;

    localparam int DEF_MAX_WINDOW   = 16;
    localparam int DEF_SAMPLE_WIDTH = 32;

    localparam int CFG_WIDTH   = 5;
    localparam int ADDR_WIDTH  = 3;
    localparam int DATA_WIDTH  = 32;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = CFG_WIDTH'(3);

    // register index, taken from paddr above the byte lanes
    localparam logic [ADDR_WIDTH-3:0] REG_WINDOW_SIZE = '0;

    typedef struct packed {
        logic insert;
        logic evict;
        logic med_lo;
        logic med_hi;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: hdl/sliding_window_median.sv
// top level of the sliding window median filter: register port and block wiring
//
// Sliding window median filter. Each accepted request carries one signed sample;
// the block keeps the newest window_size samples both in arrival order and in
// ascending order (a chain of compare-and-shift cells), and returns for each
// request twice the median of the samples held, plus the number held. While
// the window fills the median is over what has arrived; for an even count the
// result is the sum of the two middle samples. window_size is register 0 of
// the APB port (byte address 0, 5 bits, reset 3); 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW. Shrinking the window drops the surplus oldest
// samples on the next request. Each request is inserted, then one surplus
// sample is evicted per cycle through the cell chain, then the low and high
// middle are read before the next request is accepted. The median is read
// through a single read port of the sorted cells, one middle entry a cycle
// unless the high read waits for a free result register. The result sits in an
// output register, so the next request is taken while a result waits; the
// block stalls only when a second result is ready before the first is taken.
`default_nettype none
module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // request channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    // result channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [SAMPLE_WIDTH:0]               o_median_doubled,
    output logic [$clog2(MAX_WINDOW+1)-1:0]            o_fill_count,
    // register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [swm_pkg::ADDR_WIDTH-1:0]        paddr,
    input  wire logic [swm_pkg::DATA_WIDTH-1:0]        pwdata,
    output logic [swm_pkg::DATA_WIDTH-1:0]             prdata,
    output logic                                       pready
);
    import swm_pkg::*;

    logic [CFG_WIDTH-1:0]    r_window_size;
    logic [ADDR_WIDTH-3:0]   reg_idx;
    logic                    cfg_wr;
    t_cmd                    cmd;
    t_stat                   stat;

    // register index sits above the two byte-lane bits
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // writes to any other index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
        end else if (cfg_wr && (reg_idx == REG_WINDOW_SIZE)) begin
            r_window_size <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // read data is combinational off the address, valid in the access cycle
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_SIZE) begin
            prdata = DATA_WIDTH'(r_window_size);
        end
    end

    // sequencer: insert, evict while over size, read low middle, read high middle
    swm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // sorted cells, arrival queue, median adder and the result register
    swm_dpath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample),
        .i_window_size    (r_window_size),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_median_doubled (o_median_doubled),
        .o_fill_count     (o_fill_count)
    );

endmodule
`default_nettype wire

FILE: hdl/swm_ctrl.sv
// controller state machine of the sliding window median filter
`default_nettype none
module swm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  swm_pkg::t_stat     i_stat,
    output swm_pkg::t_cmd      o_cmd
);
    import swm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVICT  = 2'd1;
    localparam logic [1:0] S_MED_HI = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_EVICT;
                end
            end
            S_EVICT: begin
                if (i_stat.over) begin
                    o_cmd.evict = 1'b1;
                end else begin
                    o_cmd.med_lo = 1'b1;
                    n_state      = S_MED_HI;
                end
            end
            S_MED_HI: begin
                if (i_stat.out_free) begin
                    o_cmd.med_hi = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/swm_dpath.sv
// datapath: sorted cell chain, arrival queue, median and result register
`default_nettype none
module swm_dpath #(
    parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  swm_pkg::t_cmd                               i_cmd,
    output swm_pkg::t_stat                              o_stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         i_sample,
    input  wire logic [swm_pkg::CFG_WIDTH-1:0]          i_window_size,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [SAMPLE_WIDTH:0]                o_median_doubled,
    output logic [$clog2(MAX_WINDOW+1)-1:0]             o_fill_count
);
    import swm_pkg::*;

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int FW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = SAMPLE_WIDTH;

    logic signed [SW-1:0] r_sorted [DEPTH];
    logic signed [SW-1:0] n_sorted [DEPTH];
    logic signed [SW-1:0] r_arr    [DEPTH];
    logic signed [SW-1:0] n_arr    [DEPTH];
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic signed [SW:0]   r_acc;
    logic signed [SW:0]   r_med;
    logic                 r_out_valid;
    logic [FW-1:0]        r_fill;

    logic [CW-1:0]        w_eff;
    logic [DEPTH-2:0]     hit;
    logic [IW-1:0]        idx_hi;
    logic [IW-1:0]        idx_lo;
    logic [IW-1:0]        idx_rd;
    logic signed [SW-1:0] rd_val;

    // effective window: zero acts as one, clipped to MAX_WINDOW
    always_comb begin
        if (i_window_size == '0) begin
            w_eff = CW'(1);
        end else if (int'(i_window_size) > MAX_WINDOW) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(i_window_size);
        end
    end

    // first held entry equal to the oldest sample, and everything after it;
    // a match only in the last cell leaves the lower cells as they are
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            hit[i] = (CW'(i) < r_count) && (r_sorted[i] == r_arr[0]);
            if (i > 0) begin
                hit[i] = hit[i] | hit[i-1];
            end
        end
    end

    always_comb begin
        n_sorted = r_sorted;
        n_arr    = r_arr;
        n_count  = r_count;
        priority if (i_cmd.insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if ((CW'(i) < r_count) && !(r_sorted[i] > i_sample)) begin
                    n_sorted[i] = r_sorted[i];
                end else if ((i > 0) && (CW'(i - 1) < r_count)
                             && (r_sorted[(i > 0) ? i - 1 : 0] > i_sample)) begin
                    n_sorted[i] = r_sorted[(i > 0) ? i - 1 : 0];
                end else begin
                    n_sorted[i] = i_sample;
                end
                if (CW'(i) == r_count) begin
                    n_arr[i] = i_sample;
                end
            end
            n_count = r_count + CW'(1);
        end else if (i_cmd.evict) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_sorted[i] = hit[i] ? r_sorted[i+1] : r_sorted[i];
                n_arr[i]    = r_arr[i+1];
            end
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // middle indexes; for an odd count both point at the single middle
    assign idx_hi = IW'(r_count >> 1);
    assign idx_lo = r_count[0] ? idx_hi : idx_hi - IW'(1);
    assign idx_rd = i_cmd.med_lo ? idx_lo : idx_hi;
    assign rd_val = r_sorted[idx_rd];

    always_ff @(posedge i_clk) begin
        r_sorted <= n_sorted;
        r_arr    <= n_arr;
        if (i_cmd.med_lo) begin
            r_acc <= (SW+1)'(rd_val);
        end
        if (i_cmd.med_hi) begin
            r_med  <= r_acc + (SW+1)'(rd_val);
            r_fill <= FW'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.med_hi) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.over     = (r_count > w_eff);
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_median_doubled = r_med;
    assign o_fill_count     = r_fill;

endmodule
`default_nettype wire

FILE: tb/swm_checker.sv
// request/result monitor and median predictor for the sliding window median filter
`timescale 1ns / 100ps
module swm_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_req_valid,
    input  wire logic                                  i_req_ready,
    input  wire logic signed [swm_pkg::DEF_SAMPLE_WIDTH-1:0] i_req_sample,
    input  wire logic                                  i_res_valid,
    input  wire logic                                  i_res_ready,
    input  wire logic signed [swm_pkg::DEF_SAMPLE_WIDTH:0] i_res_median_doubled,
    input  wire logic [swm_pkg::CFG_WIDTH-1:0]         i_res_fill_count,
    input  wire logic                                  i_psel,
    input  wire logic                                  i_penable,
    input  wire logic                                  i_pwrite,
    input  wire logic                                  i_pready,
    input  wire logic [swm_pkg::ADDR_WIDTH-1:0]        i_paddr,
    input  wire logic [swm_pkg::DATA_WIDTH-1:0]        i_pwdata,
    output int                                         o_fail_count,
    output int                                         o_pending
);
    import swm_pkg::*;

    localparam int SW   = DEF_SAMPLE_WIDTH;
    localparam int MAXW = DEF_MAX_WINDOW;

    typedef logic signed [SW-1:0] t_sample;

    typedef struct packed {
        logic signed [SW:0]   median_doubled;
        logic [CFG_WIDTH-1:0] fill_count;
    } t_median;

    t_sample              window_sorted [MAXW+1];
    t_sample              window_arrival [MAXW+1];
    int                   held;
    logic [CFG_WIDTH-1:0] window_cfg;
    t_median              median_expected [$];
    int                   fails = 0;

    // insert into both lists, evict oldest beyond the window, return the new median
    function automatic t_median insert_sample(t_sample s);
        int      w;
        int      n;
        int      pos;
        int      i;
        int      j;
        bit      found;
        t_median r;
        w = window_cfg;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        n = held;
        pos = n;
        while (pos > 0 && window_sorted[pos-1] > s) begin
            window_sorted[pos] = window_sorted[pos-1];
            pos--;
        end
        window_sorted[pos] = s;
        window_arrival[n] = s;
        n++;
        // a shrunk window drops all surplus samples at once
        while (n > w) begin
            found = 0;
            for (i = 0; i < n; i++) begin
                if (!found && window_sorted[i] == window_arrival[0]) begin
                    for (j = i; j < n - 1; j++) window_sorted[j] = window_sorted[j+1];
                    found = 1;
                end
            end
            for (j = 0; j < n - 1; j++) window_arrival[j] = window_arrival[j+1];
            n--;
        end
        held = n;
        if (n % 2)
            r.median_doubled = window_sorted[n/2] + window_sorted[n/2];
        else
            r.median_doubled = window_sorted[n/2-1] + window_sorted[n/2];
        r.fill_count = n[CFG_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_median want;
        if (!i_rst_n) begin
            held = 0;
            window_cfg = WINDOW_SIZE_RESET;
            median_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                    i_paddr[ADDR_WIDTH-1:2] == REG_WINDOW_SIZE)
                window_cfg = i_pwdata[CFG_WIDTH-1:0];
            // retire the older result before a same-cycle request is queued
            if (i_res_valid && i_res_ready) begin
                if (median_expected.size() == 0) begin
                    $error("unexpected result: median_doubled %0d fill_count %0d",
                           i_res_median_doubled, i_res_fill_count);
                    fails++;
                end else begin
                    want = median_expected[0];
                    median_expected.delete(0);
                    if (i_res_median_doubled !== want.median_doubled) begin
                        $error("median_doubled: expected %0d, got %0d",
                               want.median_doubled, i_res_median_doubled);
                        fails++;
                    end
                    if (i_res_fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, i_res_fill_count);
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                median_expected = {median_expected, insert_sample(i_req_sample)};
        end
        o_pending    <= median_expected.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb.sv
// testbench top: sample stimulus, window size changes and verdict for the median filter
`timescale 1ns / 100ps
module tb;
    import swm_pkg::*;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int PHASE_ITEMS = 115;
    localparam int NUM_PHASES  = 12;
    localparam int HOLD_CYCLES = 300;   // long result back-pressure, fills the block

    typedef logic signed [SW-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = 32'sh7fffffff;
    localparam t_sample SAMPLE_MIN = 32'sh80000000;

    // a register index past the end of the map; writes to it must change nothing
    localparam logic [ADDR_WIDTH-3:0] REG_UNMAPPED = REG_WINDOW_SIZE + 1'b1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    t_sample                 i_sample;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [SW:0]      o_median_doubled;
    logic [CFG_WIDTH-1:0]    o_fill_count;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_WIDTH-1:0]   paddr;
    logic [DATA_WIDTH-1:0]   pwdata;
    logic [DATA_WIDTH-1:0]   prdata;
    logic                    pready;

    int                      fail_count;
    int                      pending;

    // gaps on both sides switch off in some phases so full-rate stretches occur too
    bit                      idle_on;
    int                      rx_hold_len;

    // window sizes per phase: extremes, zero (acts as one), oversized (acts as
    // sixteen), and drops from a full window to force multi-sample eviction
    logic [CFG_WIDTH-1:0] phase_window [NUM_PHASES] =
        '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16, 5'd4, 5'd9, 5'd1, 5'd3};

    // window 3 while filling: max pair overflows 32 bits, min triple, equal samples
    t_sample fill_requests [14] = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                                    SAMPLE_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd5,
                                    32'sd5, 32'sd5, -32'sd5, 32'sd5, 32'sd0};
    // window 2: even counts, so the two middle samples are summed
    t_sample pair_requests [8]  = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                    SAMPLE_MAX, SAMPLE_MAX, -32'sd1, 32'sd0};

    sliding_window_median u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_median_doubled (o_median_doubled),
        .o_fill_count     (o_fill_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    swm_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_req_valid          (i_valid),
        .i_req_ready          (o_ready),
        .i_req_sample         (i_sample),
        .i_res_valid          (o_valid),
        .i_res_ready          (i_ready),
        .i_res_median_doubled (o_median_doubled),
        .i_res_fill_count     (o_fill_count),
        .i_psel               (psel),
        .i_penable            (penable),
        .i_pwrite             (pwrite),
        .i_pready             (pready),
        .i_paddr              (paddr),
        .i_pwdata             (pwdata),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // full range, clusters of small values for ties, and values at the rails
    function automatic t_sample random_sample();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 16) - 8;
            7:          return SAMPLE_MAX - $urandom_range(0, 2);
            8:          return SAMPLE_MIN + $urandom_range(0, 2);
            default:    return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
    endfunction

    // one request; valid stays high until accepted
    task automatic send_request(input t_sample s);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid  = 1'b0;
            i_sample = $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid  = 1'b1;
        i_sample = s;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // setup cycle then access cycle
    task automatic write_reg(input logic [ADDR_WIDTH-3:0] idx,
                             input logic [DATA_WIDTH-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop requests and wait for every expected result, so the block is idle
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off counted here
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            if (rx_hold_len > 0) begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready = 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b0;
        rx_hold_len = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset window size, then at window 2
        foreach (fill_requests[k]) send_request(fill_requests[k]);
        drain();
        write_reg(REG_WINDOW_SIZE, 32'd2);
        foreach (pair_requests[k]) send_request(pair_requests[k]);
        drain();

        // random phases, each at its own window size; upper data bits are noise
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_WINDOW_SIZE,
                      {(DATA_WIDTH - CFG_WIDTH)'($urandom_range(0,
                           (1 << (DATA_WIDTH - CFG_WIDTH)) - 1)), phase_window[p]});
            if (p == 6) write_reg(REG_UNMAPPED, $urandom);
            idle_on = (p % 4 != 2);
            // block fills up behind a stalled result side while requests keep coming
            if (p == 1) rx_hold_len = HOLD_CYCLES;
            repeat (PHASE_ITEMS) send_request(random_sample());
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
